FILE: design/occupancy_grid_ray_marker_assert.svh
// Assertion macros for the occupancy grid ray marker.
`ifndef OCCUPANCY_GRID_RAY_MARKER_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_MARKER_ASSERT_SVH
`ifndef SYNTHESIS
`define OGRM_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define OGRM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define OGRM_ASSERT_IMP(name, clk, rstn, ante, cons)
`define OGRM_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

FILE: design/ogrm_pkg.sv
// Shared types and constants of the occupancy grid ray marker.
package ogrm_pkg;

    localparam int GRID_SIDE_DEF  = 256;
    localparam int COORD_FRAC_DEF = 16;

    // cell coordinates saturate to +/- 2^23
    localparam int CELL_W     = 25;
    localparam int CELL_LIMIT = 8388608;
    localparam int MAJ_W      = 25;
    localparam int POS_W      = 27;

    localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [1:0] CELL_FREE     = 2'd1;
    localparam logic [1:0] CELL_OCCUPIED = 2'd2;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_DRAW  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_MAP_WIDTH  = 3'd0,
        CFG_MAP_HEIGHT = 3'd1,
        CFG_ORIGIN_X   = 3'd2,
        CFG_ORIGIN_Y   = 3'd3,
        CFG_CELL_SCALE = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CONV,
        ST_SETUP1,
        ST_SETUP2,
        ST_MULT,
        ST_DIV,
        ST_INIT,
        ST_WALK,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

FILE: design/occupancy_grid_ray_marker.sv
// Occupancy grid ray marker: grid memory, ray conversion, exact DDA walk.
//
// Keeps a GRID_SIDE x GRID_SIDE grid of 2-bit cells in one synchronous memory
// and takes one item at a time. After reset and for every clear item a sweep
// writes one cell per cycle over all GRID_SIDE*GRID_SIDE cells (65536 by
// default), with no input taken meanwhile. A read uses the registered memory
// read. A draw converts its four coordinates with products of at most 17x31
// bits, sets up the walk (SETUP1, SETUP2 and MULT states), finds the first
// minor offset with a bit-serial divider (skipped for a zero-length ray; a ray
// that misses the used area skips the walk too), then steps one cell per cycle
// along the major axis, writing those inside the map, at most GRID_SIDE cells,
// and hands over the result from its done state. A finished result waits in an
// output register, so the next item can be taken while it is pending.
module occupancy_grid_ray_marker #(
    parameter int GRID_SIDE       = ogrm_pkg::GRID_SIDE_DEF,
    parameter int COORD_FRAC_BITS = ogrm_pkg::COORD_FRAC_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_start_x,
    input  logic [31:0] s_start_y,
    input  logic [31:0] s_target_x,
    input  logic [31:0] s_target_y,
    input  logic [7:0]  s_read_col,
    input  logic [7:0]  s_read_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_cell_state,
    output logic [15:0] m_cells_written
);

`include "occupancy_grid_ray_marker_assert.svh"

    localparam int CW        = $clog2(GRID_SIDE);
    localparam int DEPTH     = GRID_SIDE * GRID_SIDE;
    localparam int AW        = $clog2(DEPTH);
    localparam int LIMW      = $clog2(GRID_SIDE + 1);
    localparam int SH        = 2 * COORD_FRAC_BITS;
    localparam int CELL_W    = ogrm_pkg::CELL_W;
    localparam int MAJ_W     = ogrm_pkg::MAJ_W;
    localparam int POS_W     = ogrm_pkg::POS_W;
    localparam int E_W       = MAJ_W + 1;
    localparam int DIV_STEPS = 2 * MAJ_W;
    localparam int DCW       = $clog2(DIV_STEPS);
    localparam logic [63:0] HALF = 64'(1) << (SH - 1);

    // configuration
    logic [8:0]  width_reg, height_reg;
    logic [31:0] orgx_reg, orgy_reg;
    logic [30:0] scale_reg;

    ogrm_pkg::state_t state_reg, state_next;

    logic [1:0]  func_reg;
    logic [31:0] pnt_reg [0:3];
    logic [7:0]  rcol_reg, rrow_reg;
    logic        clr_reply_reg;
    logic [AW-1:0] clr_cnt_reg;

    // conversion
    logic [1:0]  pt_reg, sub_reg;
    logic        neg_reg;
    logic [32:0] mag_reg;
    logic [47:0] pp_reg;
    logic [63:0] acc_reg;
    logic signed [CELL_W-1:0] cell_reg [0:3];

    // walk set-up
    logic [MAJ_W-1:0] adx_reg, ady_reg, major_reg, minor_reg, lo_reg, hi_reg;
    logic             dxneg_reg, dyneg_reg, steep_reg, dmaj_pos_reg, dmin_pos_reg;
    logic             empty_reg;
    logic [POS_W-1:0] smaj_reg, smin_reg, cmaj_reg, cmin_reg;
    logic [DIV_STEPS-1:0] dq_reg;
    logic [E_W-1:0]   rem_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [MAJ_W-1:0] i_reg;
    logic signed [E_W-1:0] e_reg;
    logic [15:0]      count_reg;

    // output register
    logic        m_valid_reg;
    logic [1:0]  m_cell_state_reg;
    logic [15:0] m_cells_written_reg;

    // memory
    logic [1:0]    grid_mem [0:DEPTH-1];
    logic [1:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr, walk_addr;
    logic [1:0]    mem_wdata;
    logic          out_load;

    // ---------------- combinational datapath ----------------
    logic [LIMW-1:0] w_eff, h_eff;
    assign w_eff = (32'(width_reg) > GRID_SIDE) ? LIMW'(GRID_SIDE) : LIMW'(width_reg);
    assign h_eff = (32'(height_reg) > GRID_SIDE) ? LIMW'(GRID_SIDE) : LIMW'(height_reg);

    logic [31:0] org_sel;
    logic [32:0] diff;
    logic [63:0] rsum, rnd, rsat;
    logic signed [CELL_W-1:0] cell_val;
    always_comb begin
        org_sel  = pt_reg[0] ? orgy_reg : orgx_reg;
        diff     = {pnt_reg[pt_reg][31], pnt_reg[pt_reg]} - {org_sel[31], org_sel};
        rsum     = acc_reg + (64'(pp_reg) << 16) + HALF;
        rnd      = rsum >> SH;
        rsat     = (rnd > 64'(ogrm_pkg::CELL_LIMIT)) ? 64'(ogrm_pkg::CELL_LIMIT) : rnd;
        cell_val = neg_reg ? -CELL_W'(rsat) : CELL_W'(rsat);
    end

    logic signed [CELL_W:0] dx, dy;
    assign dx = {cell_reg[2][CELL_W-1], cell_reg[2]} - {cell_reg[0][CELL_W-1], cell_reg[0]};
    assign dy = {cell_reg[3][CELL_W-1], cell_reg[3]} - {cell_reg[1][CELL_W-1], cell_reg[1]};

    logic                    steep, dmaj_pos, dmin_pos, empty;
    logic [MAJ_W-1:0]        major, minor;
    logic [CELL_W-1:0]       smaj, smin;
    logic [LIMW-1:0]         lim;
    logic signed [POS_W-1:0] smaj_e, lim_e, major_e, lo_t, hi_t, lo_c, hi_c;
    always_comb begin
        steep    = ady_reg > adx_reg;
        major    = steep ? ady_reg : adx_reg;
        minor    = steep ? adx_reg : ady_reg;
        smaj     = steep ? cell_reg[1] : cell_reg[0];
        smin     = steep ? cell_reg[0] : cell_reg[1];
        dmaj_pos = steep ? !dyneg_reg : !dxneg_reg;
        dmin_pos = steep ? !dxneg_reg : !dyneg_reg;
        lim      = steep ? h_eff : w_eff;
        smaj_e   = $signed({{(POS_W - CELL_W){smaj[CELL_W-1]}}, smaj});
        lim_e    = $signed(POS_W'(lim));
        major_e  = $signed(POS_W'(major));
        lo_t     = dmaj_pos ? -smaj_e : smaj_e - (lim_e - POS_W'(1));
        hi_t     = dmaj_pos ? (lim_e - POS_W'(1)) - smaj_e : smaj_e;
        lo_c     = (lo_t < 0) ? '0 : lo_t;
        hi_c     = (hi_t > major_e) ? major_e : hi_t;
        empty    = hi_c < lo_c;
    end

    logic [E_W-1:0]   rem_t;
    logic             div_bit;
    logic [MAJ_W-1:0] j0;
    logic [E_W-1:0]   e0;
    always_comb begin
        rem_t   = {rem_reg[E_W-2:0], dq_reg[DIV_STEPS-1]};
        div_bit = rem_t >= {1'b0, major_reg};
        j0      = dq_reg[MAJ_W-1:0] + MAJ_W'(rem_reg != '0);
        e0      = (rem_reg == '0) ? '0 : {1'b0, major_reg} - rem_reg;
    end

    logic [POS_W-1:0] cx, cy;
    logic             inb;
    logic signed [E_W-1:0] e_t;
    always_comb begin
        cx        = steep_reg ? cmin_reg : cmaj_reg;
        cy        = steep_reg ? cmaj_reg : cmin_reg;
        // negative coordinates compare as huge unsigned values and drop out
        inb       = (cx < POS_W'(w_eff)) && (cy < POS_W'(h_eff));
        walk_addr = AW'(cy[CW-1:0]) * AW'(GRID_SIDE) + AW'(cx[CW-1:0]);
        e_t       = e_reg - $signed({1'b0, minor_reg});
    end

    logic rd_ok;
    assign rd_ok     = (32'(rcol_reg) < GRID_SIDE) && (32'(rrow_reg) < GRID_SIDE);
    assign mem_raddr = AW'(rrow_reg) * AW'(GRID_SIDE) + AW'(rcol_reg);

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = walk_addr;
        mem_wdata  = (i_reg == major_reg) ? ogrm_pkg::CELL_OCCUPIED : ogrm_pkg::CELL_FREE;
        out_load   = 1'b0;
        case (state_reg)
            ogrm_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = ogrm_pkg::CELL_UNKNOWN;
                if (clr_cnt_reg == AW'(DEPTH - 1)) begin
                    state_next = clr_reply_reg ? ogrm_pkg::ST_DONE : ogrm_pkg::ST_IDLE;
                end
            end
            ogrm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        ogrm_pkg::FUNC_CLEAR: state_next = ogrm_pkg::ST_CLEAR;
                        ogrm_pkg::FUNC_DRAW:  state_next = ogrm_pkg::ST_CONV;
                        ogrm_pkg::FUNC_READ:  state_next = ogrm_pkg::ST_READ;
                        default:              state_next = ogrm_pkg::ST_DONE;
                    endcase
                end
            end
            ogrm_pkg::ST_CONV: begin
                if (sub_reg == 2'd3 && pt_reg == 2'd3) begin
                    state_next = ogrm_pkg::ST_SETUP1;
                end
            end
            ogrm_pkg::ST_SETUP1: state_next = ogrm_pkg::ST_SETUP2;
            ogrm_pkg::ST_SETUP2: state_next = ogrm_pkg::ST_MULT;
            ogrm_pkg::ST_MULT: begin
                if (empty_reg) begin
                    state_next = ogrm_pkg::ST_DONE;
                end else if (major_reg == '0) begin
                    state_next = ogrm_pkg::ST_INIT;
                end else begin
                    state_next = ogrm_pkg::ST_DIV;
                end
            end
            ogrm_pkg::ST_DIV: begin
                if (div_cnt_reg == DCW'(DIV_STEPS - 1)) begin
                    state_next = ogrm_pkg::ST_INIT;
                end
            end
            ogrm_pkg::ST_INIT: state_next = ogrm_pkg::ST_WALK;
            ogrm_pkg::ST_WALK: begin
                mem_we = inb;
                if (i_reg == hi_reg) begin
                    state_next = ogrm_pkg::ST_DONE;
                end
            end
            ogrm_pkg::ST_READ: state_next = ogrm_pkg::ST_DONE;
            ogrm_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ogrm_pkg::ST_IDLE;
                end
            end
            default: state_next = ogrm_pkg::ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ogrm_pkg::ST_IDLE);

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ogrm_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
            orgx_reg      <= '0;
            orgy_reg      <= '0;
            scale_reg     <= 31'd1310720;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    ogrm_pkg::CFG_MAP_WIDTH:  width_reg  <= cfg_wr_data[8:0];
                    ogrm_pkg::CFG_MAP_HEIGHT: height_reg <= cfg_wr_data[8:0];
                    ogrm_pkg::CFG_ORIGIN_X:   orgx_reg   <= cfg_wr_data;
                    ogrm_pkg::CFG_ORIGIN_Y:   orgy_reg   <= cfg_wr_data;
                    ogrm_pkg::CFG_CELL_SCALE: scale_reg  <= cfg_wr_data[30:0];
                    default: ;
                endcase
            end
            if (state_reg == ogrm_pkg::ST_IDLE && s_valid) begin
                clr_cnt_reg   <= '0;
                clr_reply_reg <= 1'b1;
            end else if (state_reg == ogrm_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ogrm_pkg::ST_IDLE: begin
                func_reg   <= s_func;
                pnt_reg[0] <= s_start_x;
                pnt_reg[1] <= s_start_y;
                pnt_reg[2] <= s_target_x;
                pnt_reg[3] <= s_target_y;
                rcol_reg   <= s_read_col;
                rrow_reg   <= s_read_row;
                pt_reg     <= '0;
                sub_reg    <= '0;
                count_reg  <= '0;
            end
            ogrm_pkg::ST_CONV: begin
                case (sub_reg)
                    2'd0: begin
                        neg_reg <= diff[32];
                        mag_reg <= diff[32] ? -diff : diff;
                    end
                    2'd1: pp_reg <= 48'(mag_reg[15:0]) * 48'(scale_reg);
                    2'd2: begin
                        acc_reg <= 64'(pp_reg);
                        pp_reg  <= 48'(mag_reg[32:16]) * 48'(scale_reg);
                    end
                    default: begin
                        cell_reg[pt_reg] <= cell_val;
                        pt_reg           <= pt_reg + 1'b1;
                    end
                endcase
                sub_reg <= sub_reg + 1'b1;
            end
            ogrm_pkg::ST_SETUP1: begin
                dxneg_reg <= dx[CELL_W];
                dyneg_reg <= dy[CELL_W];
                adx_reg   <= dx[CELL_W] ? MAJ_W'(-dx) : MAJ_W'(dx);
                ady_reg   <= dy[CELL_W] ? MAJ_W'(-dy) : MAJ_W'(dy);
            end
            ogrm_pkg::ST_SETUP2: begin
                steep_reg    <= steep;
                major_reg    <= major;
                minor_reg    <= minor;
                smaj_reg     <= {{(POS_W - CELL_W){smaj[CELL_W-1]}}, smaj};
                smin_reg     <= {{(POS_W - CELL_W){smin[CELL_W-1]}}, smin};
                dmaj_pos_reg <= dmaj_pos;
                dmin_pos_reg <= dmin_pos;
                lo_reg       <= lo_c[MAJ_W-1:0];
                hi_reg       <= hi_c[MAJ_W-1:0];
                empty_reg    <= empty;
            end
            ogrm_pkg::ST_MULT: begin
                dq_reg      <= DIV_STEPS'(lo_reg) * DIV_STEPS'(minor_reg);
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ogrm_pkg::ST_DIV: begin
                rem_reg     <= div_bit ? rem_t - {1'b0, major_reg} : rem_t;
                dq_reg      <= {dq_reg[DIV_STEPS-2:0], div_bit};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            ogrm_pkg::ST_INIT: begin
                i_reg    <= lo_reg;
                e_reg    <= $signed(e0);
                cmaj_reg <= dmaj_pos_reg ? smaj_reg + POS_W'(lo_reg) : smaj_reg - POS_W'(lo_reg);
                cmin_reg <= dmin_pos_reg ? smin_reg + POS_W'(j0) : smin_reg - POS_W'(j0);
            end
            ogrm_pkg::ST_WALK: begin
                if (inb && count_reg != 16'hFFFF) begin
                    count_reg <= count_reg + 1'b1;
                end
                i_reg    <= i_reg + 1'b1;
                cmaj_reg <= dmaj_pos_reg ? cmaj_reg + 1'b1 : cmaj_reg - 1'b1;
                // error term stays in [0, major): at most one minor step per cell
                if (e_t[E_W-1]) begin
                    e_reg    <= e_t + $signed({1'b0, major_reg});
                    cmin_reg <= dmin_pos_reg ? cmin_reg + 1'b1 : cmin_reg - 1'b1;
                end else begin
                    e_reg <= e_t;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_cell_state_reg    <= (func_reg == ogrm_pkg::FUNC_READ && rd_ok)
                                   ? rd_data_reg : ogrm_pkg::CELL_UNKNOWN;
            m_cells_written_reg <= (func_reg == ogrm_pkg::FUNC_DRAW) ? count_reg : '0;
        end
    end

    // grid memory, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= grid_mem[mem_raddr];
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_state    = m_cell_state_reg;
    assign m_cells_written = m_cells_written_reg;

    `OGRM_ASSERT_IMP(a_walk_in_range, aclk, aresetn, state_reg == ogrm_pkg::ST_WALK, i_reg >= lo_reg && i_reg <= hi_reg)
    `OGRM_ASSERT_IMP(a_err_term, aclk, aresetn, state_reg == ogrm_pkg::ST_WALK && major_reg != '0, e_reg >= 0 && e_reg < $signed({1'b0, major_reg}))
    `OGRM_ASSERT_NEXT(a_busy_after_transfer, aclk, aresetn, s_valid && s_ready, state_reg != ogrm_pkg::ST_IDLE)

endmodule
